>>> src/path_segment_projection_defines.svh
// Assertion macros shared by the checker of the path segment projection block
`ifndef PATH_SEGMENT_PROJECTION_DEFINES_SVH
`define PATH_SEGMENT_PROJECTION_DEFINES_SVH

// same-cycle implication, sampled on clk, masked while rst_n is low
`define PSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, masked while rst_n is low
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psp_pkg.sv
// Types, constants and tables of the path segment projection block
package psp_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF = 64;
  localparam int BACK_SPAN_DEF  = 2;
  localparam int AHEAD_SPAN_DEF = 6;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // arithmetic constants
  localparam logic signed [63:0] LEN_MIN     = 64'sd1074;  // 1e-6 m^2 in Q32.30
  localparam logic signed [15:0] PI_Q13      = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [4:0]         CORDIC_STEPS = 5'd20;
  localparam logic [4:0]         DIV_STEPS    = 5'd30;
  localparam logic [5:0]         SQRT_STEPS   = 6'd32;

  // multiplier operand selects
  localparam logic [3:0] MS_NONE = 4'd0;
  localparam logic [3:0] MS_DXDX = 4'd1;
  localparam logic [3:0] MS_DZDZ = 4'd2;
  localparam logic [3:0] MS_AXDX = 4'd3;
  localparam logic [3:0] MS_AZDZ = 4'd4;
  localparam logic [3:0] MS_TDX  = 4'd5;
  localparam logic [3:0] MS_TDZ  = 4'd6;
  localparam logic [3:0] MS_XOXO = 4'd7;
  localparam logic [3:0] MS_ZOZO = 4'd8;
  localparam logic [3:0] MS_DXZO = 4'd9;
  localparam logic [3:0] MS_DZXO = 4'd10;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LD   = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  typedef struct packed {
    logic               op;
    logic [5:0]         wp_index;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;
    logic [6:0]         hint_index;
  } psp_in_t;

  typedef struct packed {
    logic signed [31:0] cross_track;
    logic signed [15:0] heading;
    logic [6:0]         seg_index;
  } psp_out_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr;
    logic       q_load;
    logic       rd_a;
    logic       rd_b;
    logic       cap_p1;
    logic       cap_p2;
    logic [3:0] mul_sel;
    logic [1:0] acc_op;
    logic       cap_len;
    logic       div_init;
    logic       div_step;
    logic       cap_xo;
    logic       cap_zo;
    logic       keep;
    logic       seg_next;
    logic       cap_m1;
    logic       cap_sign;
    logic       sq_init;
    logic       sq_step;
    logic       hd_init;
    logic       hd_norm;
    logic       hd_step;
    logic       res_load;
  } psp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;
    logic len_small;
    logic div_done;
    logic sq_done;
    logic norm_done;
    logic cord_done;
  } psp_sts_t;

  // CORDIC arctangent table, units of 2^-20 rad
  function automatic logic [19:0] atan_lut(input logic [4:0] idx);
    logic [19:0] v;
    unique case (idx)
      5'd0:  v = 20'd823550;
      5'd1:  v = 20'd486170;
      5'd2:  v = 20'd256879;
      5'd3:  v = 20'd130396;
      5'd4:  v = 20'd65451;
      5'd5:  v = 20'd32757;
      5'd6:  v = 20'd16383;
      5'd7:  v = 20'd8192;
      5'd8:  v = 20'd4096;
      5'd9:  v = 20'd2048;
      5'd10: v = 20'd1024;
      5'd11: v = 20'd512;
      5'd12: v = 20'd256;
      5'd13: v = 20'd128;
      5'd14: v = 20'd64;
      5'd15: v = 20'd32;
      5'd16: v = 20'd16;
      5'd17: v = 20'd8;
      5'd18: v = 20'd4;
      5'd19: v = 20'd2;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/psp_ctrl.sv
// Sequencing state machine of the path segment projection block
module psp_ctrl
  import psp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  psp_sts_t sts,
  output psp_cmd_t cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WIN  = 5'd1;
  localparam logic [4:0] S_RD0  = 5'd2;
  localparam logic [4:0] S_RD1  = 5'd3;
  localparam logic [4:0] S_DIF  = 5'd4;
  localparam logic [4:0] S_M1   = 5'd5;
  localparam logic [4:0] S_M2   = 5'd6;
  localparam logic [4:0] S_M3   = 5'd7;
  localparam logic [4:0] S_M4   = 5'd8;
  localparam logic [4:0] S_M5   = 5'd9;
  localparam logic [4:0] S_CHK  = 5'd10;
  localparam logic [4:0] S_DIV  = 5'd11;
  localparam logic [4:0] S_T1   = 5'd12;
  localparam logic [4:0] S_T2   = 5'd13;
  localparam logic [4:0] S_T3   = 5'd14;
  localparam logic [4:0] S_E1   = 5'd15;
  localparam logic [4:0] S_E2   = 5'd16;
  localparam logic [4:0] S_E3   = 5'd17;
  localparam logic [4:0] S_KEEP = 5'd18;
  localparam logic [4:0] S_F0   = 5'd19;
  localparam logic [4:0] S_F1   = 5'd20;
  localparam logic [4:0] S_F2   = 5'd21;
  localparam logic [4:0] S_SQ   = 5'd22;
  localparam logic [4:0] S_NRM  = 5'd23;
  localparam logic [4:0] S_COR  = 5'd24;
  localparam logic [4:0] S_OUT  = 5'd25;

  logic [4:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;
  assign slot_free = !ovld_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.q_load = 1'b1;
            state_nxt  = S_WIN;
          end
        end
      end
      S_WIN:  state_nxt = sts.more ? S_RD0 : S_F0;
      S_RD0: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd_b   = 1'b1;
        cmd.cap_p1 = 1'b1;
        state_nxt  = S_DIF;
      end
      S_DIF: begin
        cmd.cap_p2 = 1'b1;
        state_nxt  = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MS_DXDX;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MS_DZDZ;
        cmd.acc_op  = ACC_LD;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = MS_AXDX;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_M4;
      end
      S_M4: begin
        cmd.mul_sel = MS_AZDZ;
        cmd.acc_op  = ACC_LD;
        cmd.cap_len = 1'b1;
        state_nxt   = S_M5;
      end
      S_M5: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        if (sts.len_small) begin
          cmd.seg_next = 1'b1;
          state_nxt    = S_WIN;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_T1;
        else cmd.div_step = 1'b1;
      end
      S_T1: begin
        cmd.mul_sel = MS_TDX;
        state_nxt   = S_T2;
      end
      S_T2: begin
        cmd.mul_sel = MS_TDZ;
        cmd.cap_xo  = 1'b1;
        state_nxt   = S_T3;
      end
      S_T3: begin
        cmd.cap_zo = 1'b1;
        state_nxt  = S_E1;
      end
      S_E1: begin
        cmd.mul_sel = MS_XOXO;
        state_nxt   = S_E2;
      end
      S_E2: begin
        cmd.mul_sel = MS_ZOZO;
        cmd.acc_op  = ACC_LD;
        state_nxt   = S_E3;
      end
      S_E3: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_KEEP;
      end
      S_KEEP: begin
        cmd.keep     = 1'b1;
        cmd.seg_next = 1'b1;
        state_nxt    = S_WIN;
      end
      // side of the path, then distance root and heading of the best segment
      S_F0: begin
        cmd.mul_sel = MS_DXZO;
        state_nxt   = S_F1;
      end
      S_F1: begin
        cmd.mul_sel = MS_DZXO;
        cmd.cap_m1  = 1'b1;
        state_nxt   = S_F2;
      end
      S_F2: begin
        cmd.cap_sign = 1'b1;
        cmd.sq_init  = 1'b1;
        cmd.hd_init  = 1'b1;
        state_nxt    = S_SQ;
      end
      S_SQ: begin
        if (sts.sq_done) state_nxt = S_NRM;
        else cmd.sq_step = 1'b1;
      end
      S_NRM: begin
        if (sts.norm_done) state_nxt = S_COR;
        else cmd.hd_norm = 1'b1;
      end
      S_COR: begin
        if (sts.cord_done) state_nxt = S_OUT;
        else cmd.hd_step = 1'b1;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

endmodule

>>> src/psp_dp.sv
// Datapath: waypoint memory, multiplier, divider, square root and CORDIC
module psp_dp
  import psp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int BACK_SPAN  = BACK_SPAN_DEF,
  parameter int AHEAD_SPAN = AHEAD_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  psp_in_t    in_item,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  psp_cmd_t   cmd,
  output psp_sts_t   sts,
  output psp_out_t   res
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int IW = 9;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] u;
    u = v[32] ? (~v + 33'd1) : v;
    return u[31:0];
  endfunction

  // rover minus projected point along one axis
  function automatic logic signed [32:0] ofs(input logic signed [31:0] r,
                                             input logic signed [31:0] p,
                                             input logic neg,
                                             input logic [63:0] prod);
    logic [63:0]        rnd;
    logic signed [35:0] off;
    logic signed [35:0] diff;
    rnd  = prod + 64'h2000_0000;
    off  = neg ? -$signed({2'b00, rnd[63:30]}) : $signed({2'b00, rnd[63:30]});
    diff = {{4{r[31]}}, r} - {{4{p[31]}}, p} - off;
    return diff[32:0];
  endfunction

  // waypoint store, x in the upper half
  logic [63:0] mem [MAX_POINTS];
  logic [63:0] rd_r;
  logic [AW-1:0] rd_addr;

  logic [6:0]          plen_r;
  logic [6:0]          count;
  logic [IW-1:0]       i_r, end_r, start_c, end_c, reach_c;
  logic signed [31:0]  rx_r, rz_r, x1_r, z1_r, x2, z2;
  logic signed [32:0]  dx_r, dz_r, ax_r, az_r, xo_r, zo_r;
  logic signed [32:0]  bdx_r, bdz_r, bxo_r, bzo_r;
  logic                found_r;
  logic signed [63:0]  best_r, acc_r, len_r, q30;
  logic [6:0]          near_r;

  logic [31:0]         ma, mb;
  logic                mneg;
  logic [63:0]         prod_r;
  logic                pneg_r;

  logic [63:0]         n_r, n2;
  logic [30:0]         t_r;
  logic [4:0]          dcnt_r;

  logic [63:0]         m1_r;
  logic                n1_r, n2_c, ge_c, sign_r;

  logic [63:0]         v_r, sres_r, strial;
  logic [62:0]         sbit_r;
  logic [5:0]          scnt_r;

  logic signed [34:0]  cx_r, cy_r, shx, shy;
  logic [34:0]         orv;
  logic signed [23:0]  cz_r, zc, a1, atan_c;
  logic [4:0]          ccnt_r;
  logic                hspec_r;
  logic signed [15:0]  ang, ang_q;

  logic [33:0]         mcr;
  logic signed [31:0]  cross_c;

  psp_out_t            res_r;

  // memory ports
  assign rd_addr = cmd.rd_b ? AW'(i_r + IW'(1)) : AW'(i_r);

  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(in_item.wp_index) < 32'(MAX_POINTS)))
      mem[AW'(in_item.wp_index)] <= {in_item.x_coord, in_item.z_coord};
    if (cmd.rd_a || cmd.rd_b)
      rd_r <= mem[rd_addr];
  end

  // search window
  assign count   = (32'(plen_r) > 32'(MAX_POINTS)) ? 7'(MAX_POINTS) : plen_r;
  assign reach_c = IW'(in_item.hint_index) + IW'(AHEAD_SPAN);
  assign start_c = (IW'(in_item.hint_index) > IW'(BACK_SPAN)) ?
                   IW'(in_item.hint_index) - IW'(BACK_SPAN) : '0;
  assign end_c   = (count == 7'd0) ? '0 :
                   (reach_c >= IW'(count)) ? IW'(count) - IW'(1) : reach_c;

  assign x2 = rd_r[63:32];
  assign z2 = rd_r[31:0];

  // multiplier operand select
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    unique case (cmd.mul_sel)
      MS_DXDX: begin ma = mag33(dx_r); mb = mag33(dx_r); end
      MS_DZDZ: begin ma = mag33(dz_r); mb = mag33(dz_r); end
      MS_AXDX: begin ma = mag33(ax_r); mb = mag33(dx_r); mneg = ax_r[32] ^ dx_r[32]; end
      MS_AZDZ: begin ma = mag33(az_r); mb = mag33(dz_r); mneg = az_r[32] ^ dz_r[32]; end
      MS_TDX:  begin ma = {1'b0, t_r}; mb = mag33(dx_r); end
      MS_TDZ:  begin ma = {1'b0, t_r}; mb = mag33(dz_r); end
      MS_XOXO: begin ma = mag33(xo_r); mb = mag33(xo_r); end
      MS_ZOZO: begin ma = mag33(zo_r); mb = mag33(zo_r); end
      MS_DXZO: begin ma = mag33(bdx_r); mb = mag33(bzo_r); mneg = bdx_r[32] ^ bzo_r[32]; end
      MS_DZXO: begin ma = mag33(bdz_r); mb = mag33(bxo_r); mneg = bdz_r[32] ^ bxo_r[32]; end
      default: begin ma = '0; mb = '0; mneg = 1'b0; end
    endcase
  end

  assign q30 = pneg_r ? -$signed({2'b00, prod_r[63:2]}) : $signed({2'b00, prod_r[63:2]});

  // divider, square root and CORDIC combinational steps
  assign n2     = {n_r[62:0], 1'b0};
  assign strial = sres_r + {1'b0, sbit_r};
  assign orv    = cx_r | cy_r;
  assign shx    = cx_r >>> ccnt_r;
  assign shy    = cy_r >>> ccnt_r;
  assign atan_c = $signed({4'b0000, atan_lut(ccnt_r)});

  // side test: dx*zo >= dz*xo
  assign n2_c = pneg_r && (prod_r != 64'd0);
  assign ge_c = (n1_r != n2_c) ? n2_c : (!n1_r ? (m1_r >= prod_r) : (m1_r <= prod_r));

  // heading from CORDIC angle and quadrant
  always_comb begin
    zc    = cz_r[23] ? 24'sd0 : cz_r;
    a1    = (zc + 24'sd64) >>> 7;
    ang_q = (a1 > 24'(HALF_PI_Q13)) ? HALF_PI_Q13 : a1[15:0];
    if (bdz_r == 33'sd0)      ang = 16'sd0;
    else if (bdx_r == 33'sd0) ang = HALF_PI_Q13;
    else                      ang = ang_q;
    if (bdx_r[32]) ang = PI_Q13 - ang;
    if (bdz_r[32]) ang = -ang;
  end

  // signed, saturated cross-track magnitude
  assign mcr = {sres_r[32:0], 1'b0};
  always_comb begin
    if (sign_r) cross_c = (mcr > 34'h07FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mcr[31:0]);
    else        cross_c = (mcr > 34'h08000_0000) ? 32'sh8000_0000 : -$signed(mcr[31:0]);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r  <= '0;
      found_r <= 1'b0;
      i_r     <= '0;
      end_r   <= '0;
      dcnt_r  <= '0;
      scnt_r  <= '0;
      ccnt_r  <= '0;
      hspec_r <= 1'b0;
    end else begin
      if (cfg_we) plen_r <= cfg_data;
      if (cmd.q_load) begin
        i_r     <= start_c;
        end_r   <= end_c;
        found_r <= 1'b0;
      end else if (cmd.seg_next) begin
        i_r <= i_r + IW'(1);
      end
      if (cmd.keep && (!found_r || acc_r < best_r)) found_r <= 1'b1;
      if (cmd.div_init)
        dcnt_r <= (acc_r <= 64'sd0 || acc_r >= len_r) ? 5'd0 : DIV_STEPS;
      else if (cmd.div_step) dcnt_r <= dcnt_r - 5'd1;
      if (cmd.sq_init)      scnt_r <= SQRT_STEPS;
      else if (cmd.sq_step) scnt_r <= scnt_r - 6'd1;
      // no kept segment or an axis-aligned one needs no CORDIC pass
      if (cmd.hd_init) begin
        ccnt_r  <= '0;
        hspec_r <= !found_r || (bdx_r == 33'sd0) || (bdz_r == 33'sd0);
      end else if (cmd.hd_step) begin
        ccnt_r <= ccnt_r + 5'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      rx_r   <= in_item.x_coord;
      rz_r   <= in_item.z_coord;
      near_r <= in_item.hint_index;
    end
    if (cmd.cap_p1) begin
      x1_r <= x2;
      z1_r <= z2;
    end
    if (cmd.cap_p2) begin
      dx_r <= {x2[31], x2} - {x1_r[31], x1_r};
      dz_r <= {z2[31], z2} - {z1_r[31], z1_r};
      ax_r <= {rx_r[31], rx_r} - {x1_r[31], x1_r};
      az_r <= {rz_r[31], rz_r} - {z1_r[31], z1_r};
    end
    if (cmd.mul_sel != MS_NONE) begin
      prod_r <= 64'(ma) * 64'(mb);
      pneg_r <= mneg;
    end
    unique case (cmd.acc_op)
      ACC_LD:   acc_r <= q30;
      ACC_ADD:  acc_r <= acc_r + q30;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.cap_len) len_r <= acc_r;
    // restoring division for t in Q1.30
    if (cmd.div_init) begin
      n_r <= acc_r;
      if (acc_r <= 64'sd0)      t_r <= '0;
      else if (acc_r >= len_r)  t_r <= 31'h4000_0000;
      else                      t_r <= '0;
    end else if (cmd.div_step) begin
      if (n2 >= len_r) begin
        n_r <= n2 - len_r;
        t_r <= {t_r[29:0], 1'b1};
      end else begin
        n_r <= n2;
        t_r <= {t_r[29:0], 1'b0};
      end
    end
    if (cmd.cap_xo) xo_r <= ofs(rx_r, x1_r, dx_r[32], prod_r);
    if (cmd.cap_zo) zo_r <= ofs(rz_r, z1_r, dz_r[32], prod_r);
    if (cmd.keep && (!found_r || acc_r < best_r)) begin
      best_r <= acc_r;
      bdx_r  <= dx_r;
      bdz_r  <= dz_r;
      bxo_r  <= xo_r;
      bzo_r  <= zo_r;
      near_r <= 7'(i_r);
    end
    if (cmd.cap_m1) begin
      m1_r <= prod_r;
      n1_r <= pneg_r && (prod_r != 64'd0);
    end
    if (cmd.cap_sign) sign_r <= ge_c;
    // bit-pair square root
    if (cmd.sq_init) begin
      v_r    <= found_r ? best_r : 64'd0;
      sres_r <= '0;
      sbit_r <= 63'h4000_0000_0000_0000;
    end else if (cmd.sq_step) begin
      if (v_r >= strial) begin
        v_r    <= v_r - strial;
        sres_r <= {1'b0, sres_r[63:1]} + {1'b0, sbit_r};
      end else begin
        sres_r <= {1'b0, sres_r[63:1]};
      end
      sbit_r <= {2'b00, sbit_r[62:2]};
    end
    // CORDIC: normalise into [2^28, 2^29), then vector to the x axis
    if (cmd.hd_init) begin
      cx_r <= {3'b000, mag33(bdx_r)};
      cy_r <= {3'b000, mag33(bdz_r)};
      cz_r <= '0;
    end else if (cmd.hd_norm) begin
      if (orv >= 35'h2000_0000) begin
        cx_r <= cx_r >>> 1;
        cy_r <= cy_r >>> 1;
      end else begin
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end
    end else if (cmd.hd_step) begin
      if (cy_r > 35'sd0) begin
        cx_r <= cx_r + shy;
        cy_r <= cy_r - shx;
        cz_r <= cz_r + atan_c;
      end else begin
        cx_r <= cx_r - shy;
        cy_r <= cy_r + shx;
        cz_r <= cz_r - atan_c;
      end
    end
    if (cmd.res_load) begin
      res_r.cross_track <= found_r ? cross_c : 32'sd0;
      res_r.heading     <= found_r ? ang : 16'sd0;
      res_r.seg_index   <= near_r;
    end
  end

  assign sts.more      = (i_r < end_r);
  assign sts.len_small = (len_r < LEN_MIN);
  assign sts.div_done  = (dcnt_r == 5'd0);
  assign sts.sq_done   = (scnt_r == 6'd0);
  assign sts.norm_done = hspec_r || (orv >= 35'h1000_0000 && orv < 35'h2000_0000);
  assign sts.cord_done = hspec_r || (ccnt_r == CORDIC_STEPS);
  assign res           = res_r;

endmodule

>>> src/path_segment_projection.sv
// Top level of the path segment projection block
// A write item stores one waypoint and gives no result.
// A query scans up to BACK_SPAN+AHEAD_SPAN segments around the hint, one
// at a time, through one shared 32x32 multiplier and a one-bit-per-cycle
// divider: the divider runs only when the projection falls strictly inside
// the segment, and a segment too short to count is passed over. The
// winning segment then goes through the side test, the square root, the
// normalisation of the CORDIC operands and the CORDIC, and then loads
// the result register, waiting for that only while an earlier result
// still waits. A full window holds eight segments by default; in_ready
// is high only between items.
// A finished result waits in its output register while the next item is
// taken. path_length is written through the cfg_ channel, which is always
// ready.
module path_segment_projection
  import psp_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int BACK_SPAN  = BACK_SPAN_DEF,
  parameter int AHEAD_SPAN = AHEAD_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  psp_in_t    in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output psp_out_t   out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  psp_cmd_t cmd;
  psp_sts_t sts;

  assign cfg_ready = 1'b1;

  // controller
  psp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  psp_dp #(
    .MAX_POINTS (MAX_POINTS),
    .BACK_SPAN  (BACK_SPAN),
    .AHEAD_SPAN (AHEAD_SPAN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .res      (out_item)
  );

endmodule

>>> src/psp_checker.sv
// Port-level checks of the path segment projection block and their bind
`include "path_segment_projection_defines.svh"

module psp_checker
  import psp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input psp_in_t  in_item,
  input logic     out_valid,
  input logic     out_ready,
  input psp_out_t out_item
);

  // a waiting result holds until transferred
  `PSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // a query keeps the input side busy for at least the next cycle
  `PSP_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_item.op == OP_QUERY), !in_ready, "input taken during query")

  // a new result only appears at the end of a query
  `PSP_ASSERT_IMPL(a_res_from_query, $rose(out_valid), $past(in_ready) == 1'b0, "result without query")

  // heading stays within plus or minus pi
  `PSP_ASSERT_IMPL(a_heading_range, out_valid, ($signed(out_item.heading) <= PI_Q13) && ($signed(out_item.heading) >= -PI_Q13), "heading out of range")

endmodule

bind path_segment_projection psp_checker u_psp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
